>>> rtl/message_checksum_appender_top_macros.svh
// Assertion macros for the message checksum appender.
// Needs clk and rst_n in the scope of each use.
`ifndef MESSAGE_CHECKSUM_APPENDER_TOP_MACROS_SVH
`define MESSAGE_CHECKSUM_APPENDER_TOP_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define MCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive during reset.
`define MCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mca_pkg.sv
// Shared widths, positions and types for the message checksum appender.
// No dependencies.
package mca_pkg;

  localparam int ByteW = 8;
  localparam int PosW  = 9;

  localparam logic [PosW-1:0] PosId    = PosW'(2);
  localparam logic [PosW-1:0] PosCount = PosW'(3);
  localparam logic [PosW-1:0] PosMax   = PosW'(258);

  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_FIRST,
    CHK_SECOND
  } chk_phase_t;

endpackage

>>> rtl/mca_in_if.sv
// Input beat channel: one message byte per beat.
// Depends on mca_pkg.
interface mca_in_if
  import mca_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/mca_out_if.sv
// Result beat channel: passed-through byte or checksum byte with flags.
// Depends on mca_pkg.
interface mca_out_if
  import mca_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             is_check;
  logic             msg_end;

  modport source (output valid, output out_byte, output is_check, output msg_end,
                  input ready);
  modport sink   (input valid, input out_byte, input is_check, input msg_end,
                  output ready);
endinterface

>>> rtl/message_checksum_appender_top.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while the output is not stalled; after the byte that
// closes a message, the input is held while the two checksum beats go out.
// The output register frees the input when it is empty or its beat is being taken, outside the checksum beats.
// Reset (rst_n low, synchronous) clears position, sums and the output valid.
`include "message_checksum_appender_top_macros.svh"

module message_checksum_appender_top
  import mca_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mca_in_if.sink    in_beat,
  mca_out_if.source out_beat
);

  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;
  logic [ByteW-1:0] s1_r, s1_nxt;
  logic [ByteW-1:0] s2_r, s2_nxt;
  chk_phase_t       chk_r, chk_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ByteW-1:0] out_byte_r, out_byte_nxt;
  logic             out_check_r, out_check_nxt;
  logic             out_end_r, out_end_nxt;

  logic             slot_free;
  logic             in_acc;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] base1, base2, sum1, sum2;
  logic [PosW-1:0]  pay_idx;
  logic             last_byte;

  assign slot_free     = !out_valid_r || out_beat.ready;
  assign in_beat.ready = slot_free && (chk_r == CHK_NONE);
  assign in_acc        = in_beat.valid && in_beat.ready;
  assign b             = in_beat.in_byte;

  assign base1   = (pos_r == PosId) ? '0 : s1_r;
  assign base2   = (pos_r == PosId) ? '0 : s2_r;
  assign sum1    = base1 + b;
  assign sum2    = base2 + sum1;
  assign pay_idx = pos_r - PosCount;

  always_comb begin
    if (pos_r == PosCount) begin
      last_byte = (b == '0);
    end else begin
      last_byte = (pos_r > PosCount) && (pay_idx >= {1'b0, cnt_r});
    end
  end

  // message state
  always_comb begin
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    s1_nxt  = s1_r;
    s2_nxt  = s2_r;
    chk_nxt = chk_r;
    if (in_acc) begin
      if (pos_r < PosId) begin
        pos_nxt = pos_r + PosW'(1);
      end else begin
        s1_nxt = sum1;
        s2_nxt = sum2;
        if (pos_r == PosCount) begin
          cnt_nxt = b;
        end
        if (last_byte) begin
          pos_nxt = '0;
          chk_nxt = CHK_FIRST;
        end else begin
          pos_nxt = pos_r + PosW'(1);
        end
      end
    end else if (slot_free) begin
      unique case (chk_r)
        CHK_FIRST:  chk_nxt = CHK_SECOND;
        CHK_SECOND: chk_nxt = CHK_NONE;
        default:    chk_nxt = chk_r;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_check_nxt = out_check_r;
    out_end_nxt   = out_end_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = b;
      out_check_nxt = 1'b0;
      out_end_nxt   = 1'b0;
    end else if (slot_free) begin
      unique case (chk_r)
        CHK_FIRST: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = s1_r;
          out_check_nxt = 1'b1;
          out_end_nxt   = 1'b0;
        end
        CHK_SECOND: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = s2_r;
          out_check_nxt = 1'b1;
          out_end_nxt   = 1'b1;
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cnt_r       <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      chk_r       <= CHK_NONE;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_check_r <= out_check_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_beat.valid    = out_valid_r;
  assign out_beat.out_byte = out_byte_r;
  assign out_beat.is_check = out_check_r;
  assign out_beat.msg_end  = out_end_r;

  `MCA_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= PosMax, "byte position out of range")
  `MCA_ASSERT_NOW(a_end_is_check, out_valid_r && out_end_r, out_check_r, "message end on a data beat")
  `MCA_ASSERT_NOW(a_stall_holds_input, out_valid_r && !out_beat.ready, !in_beat.ready, "input taken while output stalled")
  `MCA_ASSERT_NEXT(a_second_follows_first, out_valid_r && out_beat.ready && out_check_r && !out_end_r, out_valid_r && out_check_r && out_end_r, "second checksum beat missing")
  `MCA_ASSERT_NOW(a_end_at_start, out_valid_r && out_beat.ready && out_end_r, pos_r == '0, "message end away from message start")

endmodule
